/* rtl/ssu_pkg.sv */
`default_nettype none
package ssu_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int POS_W    = 6;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_APPLY = 1'b1
  } fsm_t;

  // command broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_op_t;

endpackage
`default_nettype wire

/* rtl/sorted_unique_set_unit.sv */
`default_nettype none
// sorted_unique_set_unit: holds up to CAPACITY distinct signed 32-bit values in
// ascending order, one value per cell of a linear cell chain.
// input channel (in_valid/in_ready): in_kind 0 inserts in_value, 1 deletes it.
// result channel (out_valid/out_ready): one result per request with out_status,
// out_count (values held afterwards) and out_position (sorted index touched, 0 if unchanged).
// timing: in the accept cycle every cell compares its value with the key and
// registers the result; in the apply step the found/full decision is made, the
// cells shift up or down by one neighbor and the result register loads.
// a new request is accepted only once the apply step of the last one is done.
// the result register decouples the sides: a new request is accepted while a
// result still waits, but the apply step holds while out_valid is stalled.
// reset (rst_n low, synchronous) empties the set and drops any pending result;
// cell contents need no clearing since only cells below the count are read.
module sorted_unique_set_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_kind,
  input  wire logic signed [ssu_pkg::VALUE_W-1:0]   in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ssu_pkg::STATUS_W-1:0]              out_status,
  output logic [ssu_pkg::COUNT_W-1:0]               out_count,
  output logic [ssu_pkg::POS_W-1:0]                 out_position
);
  import ssu_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HELD_W = $clog2(CAPACITY + 1);

  // control state
  fsm_t               state_r, state_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic               out_valid_r, out_valid_nxt;

  // request and result payload
  logic                       kind_r, kind_nxt;
  logic signed [VALUE_W-1:0]  key_r, key_nxt;
  status_t                    status_r, status_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;

  // chain signals
  logic signed [VALUE_W-1:0]  entry [CAPACITY];
  logic [CAPACITY-1:0]        lt, eq, bnd, valid;
  cell_op_t                   op;

  logic               accept;
  logic               apply_go;
  logic               found;
  logic               full;
  logic [IDX_W-1:0]   at_idx;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == FSM_IDLE);
  assign apply_go = (state_r == FSM_APPLY) && (!out_valid_r || out_ready);

  // cell i holds a live value when it sits below the count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (HELD_W'(i) < held_r);
    end
  end

  // single cell sits at the first not-less position; encode its index
  always_comb begin
    at_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        at_idx = at_idx | IDX_W'(i);
      end
    end
  end

  assign found = |eq;
  assign full  = (held_r == HELD_W'(CAPACITY));

  // the cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                      prev_lt;
    logic signed [VALUE_W-1:0] prev_entry;
    logic signed [VALUE_W-1:0] next_entry;

    if (g == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = entry[0];
    end else begin : g_mid
      assign prev_lt    = lt[g-1];
      assign prev_entry = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = entry[g];
    end else begin : g_inner
      assign next_entry = entry[g+1];
    end

    ssu_cell u_cell (
      .clk        (clk),
      .op         (op),
      .valid      (valid[g]),
      .cmp_key    (in_value),
      .key        (key_r),
      .prev_lt    (prev_lt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entry[g]),
      .lt         (lt[g]),
      .eq         (eq[g]),
      .bnd        (bnd[g])
    );
  end

  // sequencer: compare on accept, decide and shift in the apply step
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    op            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          op.cmp_en = 1'b1;
          kind_nxt  = in_kind;
          key_nxt   = in_value;
          state_nxt = FSM_APPLY;
        end
      end
      FSM_APPLY: begin
        if (apply_go) begin
          pos_nxt = '0;
          if (kind_r == KIND_INSERT) begin
            if (found) begin
              status_nxt = ST_DUPLICATE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              op.ins_en  = 1'b1;
              held_nxt   = held_r + 1'b1;
              status_nxt = ST_INSERTED;
              pos_nxt    = POS_W'(at_idx);
            end
          end else begin
            if (found) begin
              op.del_en  = 1'b1;
              held_nxt   = held_r - 1'b1;
              status_nxt = ST_REMOVED;
              pos_nxt    = POS_W'(at_idx);
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          count_nxt     = COUNT_W'(held_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
    pos_r    <= pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_count    = count_r;
  assign out_position = pos_r;

endmodule
`default_nettype wire

/* rtl/ssu_cell.sv */
`default_nettype none
module ssu_cell (
  input  wire logic                                 clk,
  input  wire ssu_pkg::cell_op_t                    op,
  input  wire logic                                 valid,
  input  wire logic signed [ssu_pkg::VALUE_W-1:0]   cmp_key,
  input  wire logic signed [ssu_pkg::VALUE_W-1:0]   key,
  input  wire logic                                 prev_lt,
  input  wire logic signed [ssu_pkg::VALUE_W-1:0]   prev_entry,
  input  wire logic signed [ssu_pkg::VALUE_W-1:0]   next_entry,
  output logic signed [ssu_pkg::VALUE_W-1:0]        entry,
  output logic                                      lt,
  output logic                                      eq,
  output logic                                      bnd
);
  import ssu_pkg::*;

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic                      lt_r, lt_nxt;
  logic                      eq_r, eq_nxt;

  always_comb begin
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    if (op.cmp_en) begin
      lt_nxt = valid && (entry_r < cmp_key);
      eq_nxt = valid && (entry_r == cmp_key);
    end
    // insert: cells at or above the slot move up, the slot takes the key
    if (op.ins_en && !lt_r) begin
      entry_nxt = prev_lt ? key : prev_entry;
    end
    // delete: cells at or above the match pull from the right
    if (op.del_en && !lt_r && valid) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;
  assign bnd   = !lt_r && prev_lt;

endmodule
`default_nettype wire
